/* rtl/core/lkm_pkg.sv */
// Package for the LED-driver / keypad two-wire master.
// Holds phase codes, request codes, register indexes and the shared structs.
// No dependencies.
`default_nettype none

package lkm_pkg;

    // Widths fixed by the bus format
    localparam int unsigned LKM_PHASE_W   = 5;
    localparam int unsigned LKM_BYTE_W    = 8;
    localparam int unsigned LKM_BITCNT_W  = 4;
    localparam int unsigned LKM_CFG_IDX_W = 1;

    // Sequencer phases
    localparam logic [LKM_PHASE_W-1:0] PH_IDLE    = 5'd0;
    localparam logic [LKM_PHASE_W-1:0] PH_STA_A   = 5'd1;
    localparam logic [LKM_PHASE_W-1:0] PH_STA_B   = 5'd2;
    localparam logic [LKM_PHASE_W-1:0] PH_W1_LO   = 5'd3;
    localparam logic [LKM_PHASE_W-1:0] PH_W1_HI   = 5'd4;
    localparam logic [LKM_PHASE_W-1:0] PH_A1_CLK  = 5'd5;
    localparam logic [LKM_PHASE_W-1:0] PH_A1_WAIT = 5'd6;
    localparam logic [LKM_PHASE_W-1:0] PH_A1_TAIL = 5'd7;
    localparam logic [LKM_PHASE_W-1:0] PH_W2_LO   = 5'd8;
    localparam logic [LKM_PHASE_W-1:0] PH_W2_HI   = 5'd9;
    localparam logic [LKM_PHASE_W-1:0] PH_R_LO    = 5'd10;
    localparam logic [LKM_PHASE_W-1:0] PH_R_HI    = 5'd11;
    localparam logic [LKM_PHASE_W-1:0] PH_A2_CLK  = 5'd12;
    localparam logic [LKM_PHASE_W-1:0] PH_A2_WAIT = 5'd13;
    localparam logic [LKM_PHASE_W-1:0] PH_A2_TAIL = 5'd14;
    localparam logic [LKM_PHASE_W-1:0] PH_STO_A   = 5'd15;
    localparam logic [LKM_PHASE_W-1:0] PH_STO_B   = 5'd16;
    localparam logic [LKM_PHASE_W-1:0] PH_STO_C   = 5'd17;

    // Request types
    localparam logic [1:0] REQ_RAW   = 2'd0;
    localparam logic [1:0] REQ_DIGIT = 2'd1;
    localparam logic [1:0] REQ_KEY   = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    // Register indexes
    localparam logic [LKM_CFG_IDX_W-1:0] CFG_HALF_PERIOD = 1'b0;
    localparam logic [LKM_CFG_IDX_W-1:0] CFG_ACK_LIMIT   = 1'b1;

    // Bus constants
    localparam logic [LKM_BYTE_W-1:0] DIGIT_BASE_ADDR  = 8'h68;
    localparam logic [LKM_BYTE_W-1:0] KEY_READ_CMD     = 8'h49;
    localparam logic [LKM_BITCNT_W-1:0] BITS_PER_BYTE  = 4'd8;
    localparam logic [LKM_BYTE_W-1:0] HALF_PERIOD_RST  = 8'd5;
    localparam logic [LKM_BYTE_W-1:0] ACK_LIMIT_RST    = 8'd100;

    typedef struct packed {
        logic [LKM_BYTE_W-1:0] half_period_ticks;
        logic [LKM_BYTE_W-1:0] ack_poll_limit;
    } lkm_cfg_t;

    typedef struct packed {
        logic                  cmd_valid;
        logic [1:0]            req_type;
        logic [LKM_BYTE_W-1:0] addr_byte;
        logic [1:0]            digit_index;
        logic [LKM_BYTE_W-1:0] data_byte;
        logic                  sda_in;
    } lkm_item_t;

    typedef struct packed {
        logic                  scl_out;
        logic                  sda_out;
        logic                  busy_res;
        logic                  done_res;
        logic [LKM_BYTE_W-1:0] key_value;
        logic                  ack_missing;
    } lkm_result_t;

    typedef struct packed {
        logic [LKM_PHASE_W-1:0]  phase;
        logic [LKM_BYTE_W-1:0]   tick_count;
        logic [LKM_BITCNT_W-1:0] bit_count;
        logic [LKM_BYTE_W-1:0]   shift_byte;
        logic [LKM_BYTE_W-1:0]   second_byte;
        logic [LKM_BYTE_W-1:0]   poll_count;
        logic                    read_mode;
        logic                    ack_fail;
    } lkm_state_t;

endpackage

`default_nettype wire

/* rtl/core/lkm_step.sv */
// One tick of the two-wire bus sequencer: next state and pin levels.
// Pure combinational logic between the input register and the result register.
// Depends on lkm_pkg.
`default_nettype none

module lkm_step (
    input  wire lkm_pkg::lkm_cfg_t    cfg,
    input  wire lkm_pkg::lkm_item_t   item,
    input  wire lkm_pkg::lkm_state_t  state_cur,
    output lkm_pkg::lkm_state_t       state_next,
    output lkm_pkg::lkm_result_t      res
);
    import lkm_pkg::*;

    lkm_state_t              st;
    logic [LKM_BYTE_W-1:0]   half_eff;
    logic [LKM_BYTE_W:0]     tick_inc;
    logic                    tick_end;
    logic [LKM_BYTE_W-1:0]   tick_upd;
    logic [LKM_BYTE_W:0]     poll_inc;
    logic                    poll_over;
    logic [LKM_BITCNT_W-1:0] bits_inc;
    logic                    msb;

    always_comb
    begin
        st = state_cur;
        res.scl_out   = 1'b1;
        res.sda_out   = 1'b1;
        res.busy_res  = 1'b1;
        res.done_res  = 1'b0;
        res.key_value = '0;

        // Start a transaction from idle
        if (st.phase == PH_IDLE && item.cmd_valid && item.req_type != REQ_NONE)
        begin
            case (item.req_type)
                REQ_RAW:
                begin
                    st.shift_byte = item.addr_byte;
                    st.read_mode  = 1'b0;
                end
                REQ_DIGIT:
                begin
                    st.shift_byte = DIGIT_BASE_ADDR
                                  + {{(LKM_BYTE_W-3){1'b0}}, item.digit_index, 1'b0};
                    st.read_mode  = 1'b0;
                end
                default:
                begin
                    st.shift_byte = KEY_READ_CMD;
                    st.read_mode  = 1'b1;
                end
            endcase
            st.second_byte = item.data_byte;
            st.bit_count   = '0;
            st.tick_count  = '0;
            st.poll_count  = '0;
            st.ack_fail    = 1'b0;
            st.phase       = PH_STA_A;
        end

        msb = st.shift_byte[LKM_BYTE_W-1];

        // Phase timer: a zero half period counts as one tick
        half_eff = (cfg.half_period_ticks == '0) ? 8'd1 : cfg.half_period_ticks;
        tick_inc = {1'b0, st.tick_count} + 1'b1;
        tick_end = (tick_inc >= {1'b0, half_eff});
        tick_upd = tick_end ? '0 : tick_inc[LKM_BYTE_W-1:0];

        // Acknowledge poll counter
        poll_inc  = {1'b0, st.poll_count} + 1'b1;
        poll_over = (poll_inc >= {1'b0, cfg.ack_poll_limit});

        bits_inc = st.bit_count + 1'b1;

        case (st.phase)
            PH_STA_A:
            begin
                st.tick_count = tick_upd;
                if (tick_end)
                    st.phase = PH_STA_B;
            end
            PH_STA_B:
            begin
                res.sda_out   = 1'b0;
                st.tick_count = tick_upd;
                if (tick_end)
                begin
                    st.bit_count = '0;
                    st.phase     = PH_W1_LO;
                end
            end
            PH_W1_LO, PH_W2_LO:
            begin
                res.scl_out   = 1'b0;
                res.sda_out   = msb;
                st.tick_count = tick_upd;
                if (tick_end)
                    st.phase = (st.phase == PH_W1_LO) ? PH_W1_HI : PH_W2_HI;
            end
            PH_W1_HI, PH_W2_HI:
            begin
                res.sda_out   = msb;
                st.tick_count = tick_upd;
                if (tick_end)
                begin
                    st.shift_byte = {st.shift_byte[LKM_BYTE_W-2:0], 1'b0};
                    st.bit_count  = bits_inc;
                    if (bits_inc >= BITS_PER_BYTE)
                        st.phase = (st.phase == PH_W1_HI) ? PH_A1_CLK : PH_A2_CLK;
                    else
                        st.phase = (st.phase == PH_W1_HI) ? PH_W1_LO : PH_W2_LO;
                end
            end
            PH_R_LO:
            begin
                res.scl_out   = 1'b0;
                st.tick_count = tick_upd;
                if (tick_end)
                    st.phase = PH_R_HI;
            end
            PH_R_HI:
            begin
                st.tick_count = tick_upd;
                if (tick_end)
                begin
                    // Sample SDA at the end of the high phase
                    st.shift_byte = {st.shift_byte[LKM_BYTE_W-2:0], item.sda_in};
                    st.bit_count  = bits_inc;
                    st.phase      = (bits_inc >= BITS_PER_BYTE) ? PH_A2_CLK : PH_R_LO;
                end
            end
            PH_A1_CLK, PH_A2_CLK:
            begin
                st.tick_count = tick_upd;
                if (tick_end)
                begin
                    st.poll_count = '0;
                    st.phase = (st.phase == PH_A1_CLK) ? PH_A1_WAIT : PH_A2_WAIT;
                end
            end
            PH_A1_WAIT, PH_A2_WAIT:
            begin
                res.scl_out = 1'b0;
                if (!item.sda_in)
                begin
                    st.tick_count = '0;
                    st.phase = (st.phase == PH_A1_WAIT) ? PH_A1_TAIL : PH_A2_TAIL;
                end
                else
                begin
                    st.poll_count = poll_inc[LKM_BYTE_W-1:0];
                    if (poll_over)
                    begin
                        // Give up waiting and flag the missing acknowledge
                        st.ack_fail   = 1'b1;
                        st.tick_count = '0;
                        st.phase = (st.phase == PH_A1_WAIT) ? PH_A1_TAIL : PH_A2_TAIL;
                    end
                end
            end
            PH_A1_TAIL:
            begin
                res.scl_out   = 1'b0;
                st.tick_count = tick_upd;
                if (tick_end)
                begin
                    st.bit_count = '0;
                    if (st.read_mode)
                    begin
                        st.shift_byte = '0;
                        st.phase      = PH_R_LO;
                    end
                    else
                    begin
                        st.shift_byte = st.second_byte;
                        st.phase      = PH_W2_LO;
                    end
                end
            end
            PH_A2_TAIL:
            begin
                res.scl_out   = 1'b0;
                st.tick_count = tick_upd;
                if (tick_end)
                    st.phase = PH_STO_A;
            end
            PH_STO_A:
            begin
                res.scl_out   = 1'b0;
                res.sda_out   = 1'b0;
                st.tick_count = tick_upd;
                if (tick_end)
                    st.phase = PH_STO_B;
            end
            PH_STO_B:
            begin
                res.sda_out   = 1'b0;
                st.tick_count = tick_upd;
                if (tick_end)
                    st.phase = PH_STO_C;
            end
            PH_STO_C:
            begin
                st.tick_count = tick_upd;
                if (tick_end)
                begin
                    res.done_res = 1'b1;
                    if (st.read_mode)
                        res.key_value = st.shift_byte;
                    st.phase = PH_IDLE;
                end
            end
            default:
            begin
                // Idle, and any unused code drops back to idle
                res.busy_res = 1'b0;
                st.phase     = PH_IDLE;
            end
        endcase

        res.ack_missing = st.ack_fail;
        state_next      = st;
    end

endmodule

`default_nettype wire

/* rtl/core/led_keypad_two_wire_master_top.sv */
// Top level of the LED-driver / keypad two-wire master.
// Holds the input register, sequencer state, config registers and result register.
// Depends on lkm_pkg and lkm_step.
`default_nettype none

// Each transfer on the input channel is one tick of the bus sequencer and
// produces exactly one result transfer carrying the SCL/SDA levels for that
// tick, the busy and done flags, the key byte and the missing-acknowledge
// flag. The block takes one transfer per clock cycle; each input transfer
// passes through the input register and then the result register before its
// result is offered, and the only thing that slows the rate is back-pressure
// on out_ready. Bus timing is counted in input transfers: half_period_ticks
// transfers per bus phase, and up to ack_poll_limit transfers of SDA high per
// acknowledge wait.
// Write the two registers only while no transaction is running.
module led_keypad_two_wire_master_top (
    input  wire                                clk,
    input  wire                                rst_n,
    // Input channel
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire                                cmd_valid,
    input  wire [1:0]                          req_type,
    input  wire [lkm_pkg::LKM_BYTE_W-1:0]      addr_byte,
    input  wire [1:0]                          digit_index,
    input  wire [lkm_pkg::LKM_BYTE_W-1:0]      data_byte,
    input  wire                                sda_in,
    // Result channel
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic                               scl_out,
    output logic                               sda_out,
    output logic                               busy_res,
    output logic                               done_res,
    output logic [lkm_pkg::LKM_BYTE_W-1:0]     key_value,
    output logic                               ack_missing,
    // Configuration channel
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire [lkm_pkg::LKM_CFG_IDX_W-1:0]   cfg_index,
    input  wire [lkm_pkg::LKM_BYTE_W-1:0]      cfg_data
);
    import lkm_pkg::*;

    logic        in_valid_reg;
    lkm_item_t   item_reg;
    lkm_state_t  state_reg;
    lkm_state_t  state_next;
    lkm_cfg_t    cfg_reg;
    logic        out_valid_reg;
    lkm_result_t res_reg;
    lkm_result_t res_next;
    logic        advance;

    // Move the pipeline when the result slot is free or being drained
    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_valid && in_ready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.cmd_valid   <= cmd_valid;
            item_reg.req_type    <= req_type;
            item_reg.addr_byte   <= addr_byte;
            item_reg.digit_index <= digit_index;
            item_reg.data_byte   <= data_byte;
            item_reg.sda_in      <= sda_in;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period_ticks <= HALF_PERIOD_RST;
            cfg_reg.ack_poll_limit    <= ACK_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HALF_PERIOD: cfg_reg.half_period_ticks <= cfg_data;
                CFG_ACK_LIMIT:   cfg_reg.ack_poll_limit    <= cfg_data;
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Sequencer step
    lkm_step u_step (
        .cfg        (cfg_reg),
        .item       (item_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .res        (res_next)
    );

    // Advance sequencer state once per ticked item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '{phase: PH_IDLE, default: '0};
        else if (in_valid_reg && advance)
            state_reg <= state_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg && advance)
            res_reg <= res_next;
    end

    assign out_valid   = out_valid_reg;
    assign scl_out     = res_reg.scl_out;
    assign sda_out     = res_reg.sda_out;
    assign busy_res    = res_reg.busy_res;
    assign done_res    = res_reg.done_res;
    assign key_value   = res_reg.key_value;
    assign ack_missing = res_reg.ack_missing;

endmodule

`default_nettype wire

/* rtl/core/lkm_checker.sv */
// Port-level checks for the two-wire master top level, bound to it below.
// Depends on led_keypad_two_wire_master_top and lkm_pkg.
`default_nettype none

module lkm_checker (
    input wire                           clk,
    input wire                           rst_n,
    input wire                           out_valid,
    input wire                           out_ready,
    input wire                           scl_out,
    input wire                           sda_out,
    input wire                           busy_res,
    input wire                           done_res,
    input wire [lkm_pkg::LKM_BYTE_W-1:0] key_value
);
    import lkm_pkg::*;

    // A stalled result transfer holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(scl_out) && $stable(sda_out)
            && $stable(busy_res) && $stable(done_res) && $stable(key_value))
        else $error("result payload changed while stalled");

    // The done tick is still part of the transaction
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> busy_res)
        else $error("done without busy");

    // The key byte shows only on a done tick
    a_key_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_res |-> key_value == '0)
        else $error("key byte outside done tick");

    // Idle ticks leave the bus released
    a_idle_levels: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !busy_res |-> scl_out && sda_out)
        else $error("bus not released while idle");

    // A finished transaction is followed by an idle tick or a new start phase
    a_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && done_res |=> !out_valid || !done_res)
        else $error("two done ticks in a row");

endmodule

bind led_keypad_two_wire_master_top lkm_checker u_lkm_checker (.*);

`default_nettype wire
